// File: src/mlml_pkg.sv
// Shared constants, register codes and controller/datapath interface types.
`default_nettype none
package mlml_pkg;
    localparam int MAX_CLASSES_DEF = 32;
    localparam int SCORE_FRAC_DEF  = 8;

    localparam int SCORE_W     = 16;
    localparam int LABEL_W     = 6;
    localparam int INDEX_W     = 5;
    localparam int VALUE_W     = 63;
    localparam int LOSS_W      = 56;
    localparam int GRAD_W      = 12;
    localparam int DIVISOR_W   = 22;
    localparam int DVD_W       = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int DIM_CFG_W   = 6;
    localparam int FRAMES_W    = 16;
    localparam int OUT_FRAC    = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_DIM      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_AVG = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAMES   = 2'd2;

    localparam logic KIND_GRAD = 1'b0;
    localparam logic KIND_LOSS = 1'b1;

    localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    typedef struct packed {
        logic accept;
        logic clr_frame;
        logic mark_step;
        logic lbl_init;
        logic lbl_next;
        logic lbl_start;
        logic hinge_step;
        logic tfix;
        logic grad_start;
        logic div_grad;
        logic div_loss;
        logic out_grad;
        logic out_loss;
    } cmd_t;

    typedef struct packed {
        logic frame_close;
        logic batch_end;
        logic i_done;
        logic t_skip;
        logic d_last;
        logic div_done;
        logic out_free;
    } status_t;
endpackage
`default_nettype wire

// File: src/mlml_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module mlml_div (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [mlml_pkg::DVD_W-1:0]        dividend,
    input  wire logic [mlml_pkg::DIVISOR_W-1:0]    divisor,
    output logic      [mlml_pkg::DVD_W-1:0]        quotient,
    output logic                                   done
);
    localparam int CNT_W = $clog2(mlml_pkg::DVD_W);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [CNT_W-1:0]                  cnt_reg, cnt_next;
    logic [mlml_pkg::DVD_W-1:0]        dvd_reg, dvd_next;
    logic [mlml_pkg::DIVISOR_W-1:0]    rem_reg, rem_next;
    logic [mlml_pkg::DIVISOR_W:0]      shifted;
    logic [mlml_pkg::DIVISOR_W+1:0]    trial;

    assign shifted = {rem_reg, dvd_reg[mlml_pkg::DVD_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial[mlml_pkg::DIVISOR_W+1])
            begin
                rem_next = shifted[mlml_pkg::DIVISOR_W-1:0];
                dvd_next = {dvd_reg[mlml_pkg::DVD_W-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[mlml_pkg::DIVISOR_W-1:0];
                dvd_next = {dvd_reg[mlml_pkg::DVD_W-2:0], 1'b1};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(mlml_pkg::DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign quotient = dvd_reg;
    assign done     = done_reg;
endmodule
`default_nettype wire

// File: src/mlml_dp.sv
// Datapath: stores, hinge accumulation, gradient counts, divider and output register.
`default_nettype none
module mlml_dp #(
    parameter int MAX_CLASSES         = mlml_pkg::MAX_CLASSES_DEF,
    parameter int SCORE_FRACTION_BITS = mlml_pkg::SCORE_FRAC_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire mlml_pkg::cmd_t                        cmd,
    output mlml_pkg::status_t                          status,
    input  wire logic signed [mlml_pkg::SCORE_W-1:0]   score,
    input  wire logic signed [mlml_pkg::LABEL_W-1:0]   target_label,
    input  wire logic                                  cfg_we,
    input  wire logic [mlml_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [mlml_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic                                  out_ready,
    output logic                                       out_valid,
    output logic                                       kind,
    output logic [mlml_pkg::INDEX_W-1:0]               element_index,
    output logic signed [mlml_pkg::VALUE_W-1:0]        value,
    output logic                                       last
);
    localparam int IW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int DW = $clog2(MAX_CLASSES + 1);
    localparam int ZW = mlml_pkg::SCORE_W + 2;
    localparam int LOSS_SHIFT = mlml_pkg::OUT_FRAC - SCORE_FRACTION_BITS;

    // configuration registers
    logic [mlml_pkg::DIM_CFG_W-1:0] dim_cfg_reg;
    logic                           size_avg_reg;
    logic [mlml_pkg::FRAMES_W-1:0]  frames_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_cfg_reg    <= mlml_pkg::DIM_CFG_W'(32);
            size_avg_reg   <= 1'b1;
            frames_cfg_reg <= mlml_pkg::FRAMES_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mlml_pkg::CFG_DIM:      dim_cfg_reg    <= cfg_data[mlml_pkg::DIM_CFG_W-1:0];
                mlml_pkg::CFG_SIZE_AVG: size_avg_reg   <= cfg_data[0];
                mlml_pkg::CFG_FRAMES:   frames_cfg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [DW-1:0]                 dim;
    logic [mlml_pkg::FRAMES_W-1:0] frames;

    always_comb
    begin
        priority if (dim_cfg_reg == '0)
            dim = DW'(1);
        else if (dim_cfg_reg > mlml_pkg::DIM_CFG_W'(MAX_CLASSES))
            dim = DW'(MAX_CLASSES);
        else
            dim = DW'(dim_cfg_reg);
        frames = (frames_cfg_reg == '0) ? mlml_pkg::FRAMES_W'(1) : frames_cfg_reg;
    end

    // stores and counters
    logic signed [mlml_pkg::SCORE_W-1:0] score_reg [MAX_CLASSES];
    logic        [mlml_pkg::LABEL_W-1:0] label_reg [MAX_CLASSES];
    logic        [MAX_CLASSES-1:0]       mark_reg;
    logic signed [mlml_pkg::GRAD_W-1:0]  grad_reg  [MAX_CLASSES];

    logic [IW-1:0]                     pos_reg;
    logic [mlml_pkg::FRAMES_W-1:0]     frame_pos_reg;
    logic [DW-1:0]                     i_reg;
    logic [DW-1:0]                     d_reg;
    logic [mlml_pkg::GRAD_W-1:0]       neg_reg;
    logic signed [mlml_pkg::SCORE_W-1:0] st_reg;
    logic [mlml_pkg::LOSS_W-1:0]       loss_reg;
    logic                              batch_end_reg;
    logic [mlml_pkg::DIVISOR_W-1:0]    divisor_reg;
    logic                              gsign_reg;

    logic [mlml_pkg::LABEL_W-1:0] lbl;
    logic [IW-1:0]                t_idx;
    logic [IW-1:0]                d_idx;
    logic [IW-1:0]                sc_idx;
    logic [IW-1:0]                gr_idx;
    logic signed [mlml_pkg::SCORE_W-1:0] sc_rd;
    logic signed [mlml_pkg::GRAD_W-1:0]  gr_rd;
    logic signed [ZW-1:0]         z;
    logic                         hit;
    logic                         frame_close;
    logic                         batch_end_now;
    logic [DW+mlml_pkg::FRAMES_W-1:0] div_prod;

    assign lbl    = label_reg[i_reg[IW-1:0]];
    assign t_idx  = lbl[IW-1:0];
    assign d_idx  = d_reg[IW-1:0];
    assign sc_idx = cmd.lbl_start ? t_idx : d_idx;
    assign gr_idx = cmd.tfix ? t_idx : d_idx;
    assign sc_rd  = score_reg[sc_idx];
    assign gr_rd  = grad_reg[gr_idx];

    assign z   = ZW'(signed'(1 << SCORE_FRACTION_BITS)) - ZW'(st_reg) + ZW'(sc_rd);
    assign hit = !mark_reg[d_idx] && (z > 0);

    assign frame_close   = ({1'b0, pos_reg} + 1'b1) >= (IW+1)'(dim);
    assign batch_end_now = ({1'b0, frame_pos_reg} + 1'b1) >= {1'b0, frames};
    assign div_prod      = DW'(dim) * (size_avg_reg ? frames : mlml_pkg::FRAMES_W'(1));

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            score_reg[pos_reg] <= score;
            label_reg[pos_reg] <= target_label;
        end
        if (cmd.clr_frame)
        begin
            mark_reg <= '0;
            for (int k = 0; k < MAX_CLASSES; k++)
                grad_reg[k] <= '0;
            batch_end_reg <= batch_end_now;
            divisor_reg   <= mlml_pkg::DIVISOR_W'(div_prod);
        end
        else
        begin
            if (cmd.mark_step && ({1'b0, lbl} < (mlml_pkg::LABEL_W+1)'(dim)))
                mark_reg[t_idx] <= 1'b1;
            if (cmd.hinge_step && hit)
                grad_reg[d_idx] <= gr_rd + 1'b1;
            if (cmd.tfix)
                grad_reg[t_idx] <= gr_rd - signed'(neg_reg);
        end
        if (cmd.lbl_start)
            st_reg <= sc_rd;
        if (cmd.div_grad)
            gsign_reg <= gr_rd[mlml_pkg::GRAD_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            frame_pos_reg <= '0;
            i_reg         <= '0;
            d_reg         <= '0;
            neg_reg       <= '0;
            loss_reg      <= '0;
        end
        else
        begin
            if (cmd.accept)
                pos_reg <= frame_close ? '0 : pos_reg + 1'b1;
            if (cmd.clr_frame || cmd.lbl_init)
                i_reg <= '0;
            else if (cmd.mark_step || cmd.lbl_next || cmd.tfix)
                i_reg <= i_reg + 1'b1;
            if (cmd.lbl_start || cmd.grad_start)
            begin
                d_reg   <= '0;
                neg_reg <= '0;
            end
            else if (cmd.hinge_step)
            begin
                d_reg <= d_reg + 1'b1;
                if (hit)
                begin
                    neg_reg  <= neg_reg + 1'b1;
                    loss_reg <= loss_reg + mlml_pkg::LOSS_W'(z);
                end
            end
            else if (cmd.out_grad)
            begin
                d_reg <= d_reg + 1'b1;
                if (status.d_last && !batch_end_reg)
                    frame_pos_reg <= frame_pos_reg + 1'b1;
            end
            if (cmd.out_loss)
            begin
                loss_reg      <= '0;
                frame_pos_reg <= '0;
            end
        end
    end

    // shared divider for gradients and the loss
    logic [mlml_pkg::GRAD_W-1:0] gmag;
    logic [mlml_pkg::DVD_W-1:0]  dvd;
    logic [mlml_pkg::DVD_W-1:0]  quot;
    logic                        div_done;

    assign gmag = gr_rd[mlml_pkg::GRAD_W-1] ? mlml_pkg::GRAD_W'(-gr_rd)
                                            : mlml_pkg::GRAD_W'(gr_rd);
    assign dvd  = cmd.div_loss ? (mlml_pkg::DVD_W'(loss_reg) << LOSS_SHIFT)
                               : (mlml_pkg::DVD_W'(gmag) << mlml_pkg::OUT_FRAC);

    mlml_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_grad || cmd.div_loss),
        .dividend (dvd),
        .divisor  (divisor_reg),
        .quotient (quot),
        .done     (div_done)
    );

    // output register
    logic out_valid_reg;
    logic [mlml_pkg::VALUE_W-1:0] gval;

    assign gval = gsign_reg ? mlml_pkg::VALUE_W'(-quot) : quot[mlml_pkg::VALUE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_grad || cmd.out_loss)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_grad)
        begin
            kind          <= mlml_pkg::KIND_GRAD;
            element_index <= mlml_pkg::INDEX_W'(d_idx);
            value         <= signed'(gval);
            last          <= status.d_last && !batch_end_reg;
        end
        else if (cmd.out_loss)
        begin
            kind          <= mlml_pkg::KIND_LOSS;
            element_index <= '0;
            value         <= (quot[mlml_pkg::DVD_W-1:mlml_pkg::VALUE_W-1] != '0)
                             ? signed'(mlml_pkg::VALUE_MAX)
                             : signed'(quot[mlml_pkg::VALUE_W-1:0]);
            last          <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        status.frame_close = frame_close;
        status.batch_end   = batch_end_reg;
        status.i_done      = (i_reg >= dim) || lbl[mlml_pkg::LABEL_W-1];
        status.t_skip      = {1'b0, lbl} >= (mlml_pkg::LABEL_W+1)'(dim);
        status.d_last      = (d_reg + 1'b1) == dim;
        status.div_done    = div_done;
        status.out_free    = !out_valid_reg || out_ready;
    end
endmodule
`default_nettype wire

// File: src/mlml_ctrl.sv
// Controller: load, mark, hinge and result sequencing.
`default_nettype none
module mlml_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire mlml_pkg::status_t status,
    output mlml_pkg::cmd_t         cmd
);
    localparam logic [3:0] S_LOAD   = 4'd0;
    localparam logic [3:0] S_MARK   = 4'd1;
    localparam logic [3:0] S_LABEL  = 4'd2;
    localparam logic [3:0] S_HINGE  = 4'd3;
    localparam logic [3:0] S_TFIX   = 4'd4;
    localparam logic [3:0] S_GSTART = 4'd5;
    localparam logic [3:0] S_GDIV   = 4'd6;
    localparam logic [3:0] S_GOUT   = 4'd7;
    localparam logic [3:0] S_LSTART = 4'd8;
    localparam logic [3:0] S_LDIV   = 4'd9;
    localparam logic [3:0] S_LOUT   = 4'd10;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (status.frame_close)
                    begin
                        cmd.clr_frame = 1'b1;
                        state_next    = S_MARK;
                    end
                end
            end
            S_MARK:
            begin
                if (status.i_done)
                begin
                    cmd.lbl_init = 1'b1;
                    state_next   = S_LABEL;
                end
                else
                    cmd.mark_step = 1'b1;
            end
            S_LABEL:
            begin
                priority if (status.i_done)
                begin
                    cmd.grad_start = 1'b1;
                    state_next     = S_GSTART;
                end
                else if (status.t_skip)
                    cmd.lbl_next = 1'b1;
                else
                begin
                    cmd.lbl_start = 1'b1;
                    state_next    = S_HINGE;
                end
            end
            S_HINGE:
            begin
                cmd.hinge_step = 1'b1;
                if (status.d_last)
                    state_next = S_TFIX;
            end
            S_TFIX:
            begin
                cmd.tfix   = 1'b1;
                state_next = S_LABEL;
            end
            S_GSTART:
            begin
                cmd.div_grad = 1'b1;
                state_next   = S_GDIV;
            end
            S_GDIV:
            begin
                if (status.div_done)
                    state_next = S_GOUT;
            end
            S_GOUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_grad = 1'b1;
                    priority if (!status.d_last)
                        state_next = S_GSTART;
                    else if (status.batch_end)
                        state_next = S_LSTART;
                    else
                        state_next = S_LOAD;
                end
            end
            S_LSTART:
            begin
                cmd.div_loss = 1'b1;
                state_next   = S_LDIV;
            end
            S_LDIV:
            begin
                if (status.div_done)
                    state_next = S_LOUT;
            end
            S_LOUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_loss = 1'b1;
                    state_next   = S_LOAD;
                end
            end
            default:
                state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_LOAD;
        else
            state_reg <= state_next;
    end
endmodule
`default_nettype wire

// File: src/multilabel_margin_loss_core.sv
// Top level of the multilabel margin loss core with gradient output.
// Elements inside a frame are stored as they arrive. The closing element starts
// evaluation: a mark pass, a hinge pass over dim scores plus a target fix per listed
// label in range, then per gradient word a start, the divider steps, done and a load,
// and the same for the loss. No input is taken during evaluation; the hinge loop and
// the shared 64-bit divider set the rate. Reset clears all control state; no clearing pass.
`default_nettype none
module multilabel_margin_loss_core #(
    parameter int MAX_CLASSES         = mlml_pkg::MAX_CLASSES_DEF,
    parameter int SCORE_FRACTION_BITS = mlml_pkg::SCORE_FRAC_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // input words
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [mlml_pkg::SCORE_W-1:0]   score,
    input  wire logic signed [mlml_pkg::LABEL_W-1:0]   target_label,
    // result words
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic                                       kind,
    output logic [mlml_pkg::INDEX_W-1:0]               element_index,
    output logic signed [mlml_pkg::VALUE_W-1:0]        value,
    output logic                                       last,
    // configuration writes
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [mlml_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [mlml_pkg::CFG_DATA_W-1:0]       cfg_data
);
    mlml_pkg::cmd_t    cmd;
    mlml_pkg::status_t status;

    // take configuration words only while waiting for input words, never mid-evaluation
    assign cfg_ready = in_ready;

    // sequence the frame: load, mark targets, hinge loop, drain results
    mlml_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // hold stores, accumulate, divide and register the result word
    mlml_dp #(
        .MAX_CLASSES         (MAX_CLASSES),
        .SCORE_FRACTION_BITS (SCORE_FRACTION_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .score         (score),
        .target_label  (target_label),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .kind          (kind),
        .element_index (element_index),
        .value         (value),
        .last          (last)
    );

    // a result word is loaded only into a free output register
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_grad || cmd.out_loss) |-> status.out_free)
        else $error("result loaded over a pending word");

    // stores are written only on an input handshake
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> (in_valid && in_ready))
        else $error("store write without input handshake");

    // the loss word always closes the run
    a_loss_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == mlml_pkg::KIND_LOSS)) |-> last)
        else $error("loss word without last");
endmodule
`default_nettype wire
